// ===== rtl/set_assoc_read_cache_random_replace_defines.svh =====
// Assertion macros for the read cache.
// No dependencies; used by modules that need clk and rst_n in scope.
`ifndef SET_ASSOC_READ_CACHE_RANDOM_REPLACE_DEFINES_SVH
`define SET_ASSOC_READ_CACHE_RANDOM_REPLACE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SARC_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cache assertion failed");

// Next-cycle implication, checked out of reset.
`define SARC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cache assertion failed");

`endif

// ===== rtl/sarc_pkg.sv =====
// Shared types and constants of the read cache.
// No dependencies.
package sarc_pkg;

    localparam int SETS       = 128;
    localparam int SET_W      = 7;
    localparam int TAG_W      = 19;
    localparam int OFF_W      = 6;
    localparam int LINE_WORDS = 16;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    localparam logic KIND_READ   = 1'b0;
    localparam logic KIND_REFILL = 1'b1;
    localparam logic RES_DATA    = 1'b0;
    localparam logic RES_FETCH   = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] address;
        logic [2:0]  length;
        logic [31:0] word;
    } item_t;

endpackage

// ===== rtl/set_assoc_read_cache_random_replace.sv =====
// Read cache, 128 sets, random replacement. A hit goes through take, lookup, tag check,
// gather and result register; a line-crossing read repeats lookup, tag check and gather.
// A miss goes through take, lookup, tag check and victim choice to the fetch request;
// refill words are stored as taken, and after the 16th the read is redone. One request
// is served at a time. After reset all 128 tag rows are cleared, with full held high.
module set_assoc_read_cache_random_replace import sarc_pkg::*;
#(
    parameter int WAYS        = 8,
    parameter int TOTAL_LINES = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        kind,
    input  logic [31:0] address,
    input  logic [2:0]  length,
    input  logic [31:0] refill_word,
    output logic        empty,
    input  logic        pop,
    output logic        result_kind,
    output logic [31:0] read_data,
    output logic [31:0] fetch_address
);

    item_t head;
    logic  avail;
    logic  take;
    logic  clearing;
    logic  res_valid;

    assign empty = !res_valid;

    sarc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .address     (address),
        .length      (length),
        .refill_word (refill_word),
        .clearing    (clearing),
        .head        (head),
        .avail       (avail),
        .take        (take)
    );

    sarc_back #(
        .WAYS        (WAYS),
        .TOTAL_LINES (TOTAL_LINES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .avail         (avail),
        .take          (take),
        .clearing      (clearing),
        .res_valid     (res_valid),
        .res_pop       (pop && res_valid),
        .result_kind   (result_kind),
        .read_data     (read_data),
        .fetch_address (fetch_address)
    );

endmodule

// ===== rtl/sarc_front.sv =====
// Front part: accepts requests, clamps the length and holds them in a short queue.
// Depends on sarc_pkg.
module sarc_front import sarc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        kind,
    input  logic [31:0] address,
    input  logic [2:0]  length,
    input  logic [31:0] refill_word,
    input  logic        clearing,
    output item_t       head,
    output logic        avail,
    input  logic        take
);

    item_t      q_mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    item_t      entry;

    assign full    = (cnt_reg == 2'd2) || clearing;
    assign do_push = push && !full;
    assign avail   = (cnt_reg != 2'd0);
    assign head    = q_mem[rd_ptr_reg];

    always_comb
    begin
        entry.kind    = kind;
        entry.address = address;
        entry.word    = refill_word;
        // a zero length reads one byte, anything above four reads four
        if (length == 3'd0)
        begin
            entry.length = 3'd1;
        end
        else if (length > 3'd4)
        begin
            entry.length = 3'd4;
        end
        else
        begin
            entry.length = length;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (take)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, take};
        end
    end

endmodule

// ===== rtl/sarc_back.sv =====
// Back part: tag lookup, data read, victim choice, refill and result register.
// Depends on sarc_pkg and the assertion macro header.
`include "set_assoc_read_cache_random_replace_defines.svh"
module sarc_back import sarc_pkg::*;
#(
    parameter int WAYS        = 8,
    parameter int TOTAL_LINES = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  item_t       head,
    input  logic        avail,
    output logic        take,
    output logic        clearing,
    output logic        res_valid,
    input  logic        res_pop,
    output logic        result_kind,
    output logic [31:0] read_data,
    output logic [31:0] fetch_address
);

    localparam int VW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LNW   = $clog2(SETS * WAYS + TOTAL_LINES) + 1;
    localparam int LW    = $clog2(TOTAL_LINES);
    localparam int DW    = LW + 4;
    localparam int ENT_W = TAG_W + 1;
    localparam int ROW_W = WAYS * ENT_W;
    localparam logic [32:0] RECIP = 33'(((64'd1 << 32) + 64'(WAYS) - 64'd1) / 64'(WAYS));

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_LOOK, ST_CHK, ST_GATH, ST_VICT, ST_EMIT
    } state_t;

    state_t             state_reg;
    logic [31:0]        pend_addr_reg;
    logic [2:0]         pend_len_reg;
    logic               second_reg;
    logic [31:0]        partial_reg;
    logic [3:0]         refill_cnt_reg;
    logic [VW-1:0]      victim_reg;
    logic               busy_reg;
    logic [15:0]        lfsr_reg;
    logic [VW-1:0]      rem_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [SET_W-1:0]   clr_reg;
    logic               hold_kind_reg;
    logic [31:0]        hold_data_reg;
    logic [31:0]        hold_faddr_reg;
    logic               out_valid_reg;
    logic               out_kind_reg;
    logic [31:0]        out_data_reg;
    logic [31:0]        out_faddr_reg;

    logic [ROW_W-1:0]   tag_mem [SETS];
    logic [ROW_W-1:0]   row_q;
    logic [31:0]        data_mem [TOTAL_LINES * LINE_WORDS];
    logic [31:0]        dq0;
    logic [31:0]        dq1;

    logic [6:0]         room;
    logic [2:0]         fl;
    logic [31:0]        part_addr;
    logic [2:0]         part_len;
    logic [SET_W-1:0]   part_set;
    logic [TAG_W-1:0]   part_tag;
    logic [OFF_W-1:0]   part_off;
    logic [LNW-1:0]     base_line;
    logic [LNW-1:0]     vl;
    logic               vl_ok;
    logic               hit;
    logic [LNW-1:0]     hit_line;
    logic [48:0]        lfsr_prod;
    logic [15:0]        lfsr_quot;
    logic [15:0]        lfsr_rem;
    logic [VW-1:0]      way_sel;
    logic [63:0]        cat;
    logic [31:0]        bytes;
    logic [31:0]        mask;
    logic               tw_en;
    logic [SET_W-1:0]   tw_addr;
    logic [ROW_W-1:0]   tw_data;
    logic               new_valid;
    logic [ROW_W-1:0]   row_upd;
    logic               dw_en;
    logic [DW-1:0]      dw_addr;
    logic [DW-1:0]      rd0;
    logic [DW-1:0]      rd1;
    logic               slot_free;
    logic               refill_now;
    logic [15:0]        lfsr_step;

    assign clearing      = (state_reg == ST_CLEAR);
    assign take          = (state_reg == ST_IDLE) && avail;
    assign res_valid     = out_valid_reg;
    assign result_kind   = out_kind_reg;
    assign read_data     = out_data_reg;
    assign fetch_address = out_faddr_reg;
    assign slot_free     = !out_valid_reg || res_pop;
    assign refill_now    = take && (head.kind == KIND_REFILL) && busy_reg;

    // split of the pending read into its two line parts
    assign room      = 7'd64 - {1'b0, pend_addr_reg[OFF_W-1:0]};
    assign fl        = ({4'd0, pend_len_reg} < room) ? pend_len_reg : room[2:0];
    assign part_addr = second_reg ? (pend_addr_reg + {29'd0, fl}) : pend_addr_reg;
    assign part_len  = second_reg ? (pend_len_reg - fl) : fl;
    assign part_set  = part_addr[12:6];
    assign part_tag  = part_addr[31:13];
    assign part_off  = part_addr[OFF_W-1:0];
    assign base_line = LNW'(part_set) * LNW'(WAYS);
    assign vl        = base_line + LNW'(way_sel);
    assign vl_ok     = (vl < LNW'(TOTAL_LINES));
    assign lfsr_step = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS) : (lfsr_reg >> 1);

    // remainder of the LFSR by the way count through a reciprocal multiply
    assign lfsr_prod = 49'(lfsr_reg) * 49'(RECIP);
    assign lfsr_quot = lfsr_prod[47:32];
    assign lfsr_rem  = lfsr_reg - (lfsr_quot * 16'(WAYS));
    assign way_sel   = (state_reg == ST_VICT) ? rem_reg : victim_reg;

    always_comb
    begin
        logic [LNW-1:0] ln;
        hit      = 1'b0;
        hit_line = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            ln = base_line + LNW'(w);
            if (!hit && (ln < LNW'(TOTAL_LINES)) && row_q[w*ENT_W + TAG_W]
                && (row_q[w*ENT_W +: TAG_W] == part_tag))
            begin
                hit      = 1'b1;
                hit_line = ln;
            end
        end
    end

    always_comb
    begin
        case (part_len)
            3'd1:    mask = 32'h0000_00ff;
            3'd2:    mask = 32'h0000_ffff;
            3'd3:    mask = 32'h00ff_ffff;
            default: mask = 32'hffff_ffff;
        endcase
        cat   = {dq1, dq0} >> {part_off[1:0], 3'b000};
        bytes = cat[31:0] & mask;
    end

    always_comb
    begin
        new_valid = (state_reg != ST_VICT);
        row_upd   = row_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            if (VW'(w) == way_sel)
            begin
                row_upd[w*ENT_W +: ENT_W] = {new_valid, part_tag};
            end
        end
    end

    always_comb
    begin
        tw_en   = 1'b0;
        tw_addr = part_set;
        tw_data = row_upd;
        if (state_reg == ST_CLEAR)
        begin
            tw_en   = 1'b1;
            tw_addr = clr_reg;
            tw_data = '0;
        end
        else if (state_reg == ST_VICT)
        begin
            tw_en = vl_ok;
        end
        else if (refill_now)
        begin
            tw_en = (refill_cnt_reg == 4'd15) && vl_ok;
        end
    end

    assign dw_en   = refill_now && vl_ok;
    assign dw_addr = {vl[LW-1:0], refill_cnt_reg};
    assign rd0     = {hit_line[LW-1:0], part_off[5:2]};
    assign rd1     = {hit_line[LW-1:0], part_off[5:2] + 4'd1};

    always_ff @(posedge clk)
    begin
        if (tw_en)
        begin
            tag_mem[tw_addr] <= tw_data;
        end
        row_q <= tag_mem[part_set];
    end

    always_ff @(posedge clk)
    begin
        if (dw_en)
        begin
            data_mem[dw_addr] <= head.word;
        end
        dq0 <= data_mem[rd0];
        dq1 <= data_mem[rd1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            pend_addr_reg  <= '0;
            pend_len_reg   <= '0;
            second_reg     <= 1'b0;
            partial_reg    <= '0;
            refill_cnt_reg <= '0;
            victim_reg     <= '0;
            busy_reg       <= 1'b0;
            lfsr_reg       <= LFSR_SEED;
            rem_reg        <= '0;
            row_reg        <= '0;
            clr_reg        <= '0;
            hold_kind_reg  <= RES_DATA;
            hold_data_reg  <= '0;
            hold_faddr_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= RES_DATA;
            out_data_reg   <= '0;
            out_faddr_reg  <= '0;
        end
        else
        begin
            // the LFSR only moves on a miss, so the remainder is settled well before use
            rem_reg <= lfsr_rem[VW-1:0];
            if (res_pop && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == SET_W'(SETS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (take && (head.kind == KIND_READ) && !busy_reg)
                    begin
                        pend_addr_reg <= head.address;
                        pend_len_reg  <= head.length;
                        second_reg    <= 1'b0;
                        partial_reg   <= '0;
                        state_reg     <= ST_LOOK;
                    end
                    else if (refill_now)
                    begin
                        refill_cnt_reg <= refill_cnt_reg + 1'b1;
                        if (refill_cnt_reg == 4'd15)
                        begin
                            busy_reg  <= 1'b0;
                            row_reg   <= row_upd;
                            state_reg <= ST_LOOK;
                        end
                    end
                end
                ST_LOOK:
                begin
                    state_reg <= ST_CHK;
                end
                ST_CHK:
                begin
                    row_reg <= row_q;
                    if (hit)
                    begin
                        state_reg <= ST_GATH;
                    end
                    else
                    begin
                        state_reg <= ST_VICT;
                    end
                end
                ST_GATH:
                begin
                    if (!second_reg && (fl < pend_len_reg))
                    begin
                        // crossing read: keep the first bytes and look up the next line
                        partial_reg <= bytes;
                        second_reg  <= 1'b1;
                        state_reg   <= ST_LOOK;
                    end
                    else
                    begin
                        hold_kind_reg  <= RES_DATA;
                        hold_faddr_reg <= '0;
                        if (second_reg)
                        begin
                            hold_data_reg <= partial_reg | (bytes << {fl, 3'b000});
                            partial_reg   <= partial_reg | (bytes << {fl, 3'b000});
                        end
                        else
                        begin
                            hold_data_reg <= bytes;
                            partial_reg   <= bytes;
                        end
                        second_reg <= 1'b0;
                        state_reg  <= ST_EMIT;
                    end
                end
                ST_VICT:
                begin
                    // hold the victim way for the refill
                    victim_reg     <= rem_reg;
                    lfsr_reg       <= lfsr_step;
                    busy_reg       <= 1'b1;
                    refill_cnt_reg <= '0;
                    row_reg        <= row_upd;
                    hold_kind_reg  <= RES_FETCH;
                    hold_data_reg  <= '0;
                    hold_faddr_reg <= {part_addr[31:OFF_W], {OFF_W{1'b0}}};
                    state_reg      <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= hold_kind_reg;
                        out_data_reg  <= hold_data_reg;
                        out_faddr_reg <= hold_faddr_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `SARC_ASSERT_NOW(a_lfsr_live, 1'b1, lfsr_reg != 16'd0)
    `SARC_ASSERT_NOW(a_no_take_clear, state_reg == ST_CLEAR, !take)
    `SARC_ASSERT_NOW(a_cnt_idle, !busy_reg, refill_cnt_reg == 4'd0)
    `SARC_ASSERT_NEXT(a_fetch_busy, state_reg == ST_VICT, busy_reg)

endmodule

// ===== test/sarc_checker.sv =====
// Checker for the read cache: watches the request and result queues, predicts every result
// and compares it field by field. Depends on sarc_pkg.
`timescale 1ns / 1ps

module sarc_checker import sarc_pkg::*;
#(
    parameter int WAYS        = 8,
    parameter int TOTAL_LINES = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        kind,
    input  logic [31:0] address,
    input  logic [2:0]  length,
    input  logic [31:0] refill_word,
    input  logic        empty,
    input  logic        pop,
    input  logic        result_kind,
    input  logic [31:0] read_data,
    input  logic [31:0] fetch_address,
    output logic        cache_busy,
    output int          pending,
    output int          fail_count
);

    typedef struct {
        logic        rkind;
        logic [31:0] data;
        logic [31:0] faddr;
    } cache_result_t;

    cache_result_t awaited_q[$];

    logic             line_valid [TOTAL_LINES];
    logic [TAG_W-1:0] line_tag   [TOTAL_LINES];
    logic [31:0]      line_data  [TOTAL_LINES*LINE_WORDS];

    logic [31:0] req_addr;
    int unsigned req_len;
    logic        upper_half;
    logic [31:0] joined;
    int unsigned word_idx;
    int unsigned victim;
    logic [15:0] lfsr;

    function automatic int unsigned head_len();
        int unsigned room;
        room = 64 - req_addr[5:0];
        return (req_len < room) ? req_len : room;
    endfunction

    function automatic logic [31:0] seg_addr();
        return upper_half ? req_addr + head_len() : req_addr;
    endfunction

    function automatic int unsigned seg_len();
        return upper_half ? req_len - head_len() : head_len();
    endfunction

    function automatic int unsigned line_idx(logic [31:0] a, int unsigned way);
        return a[12:6] * WAYS + way;
    endfunction

    function automatic int unsigned find_line(logic [31:0] a);
        int unsigned ln;
        for (int w = 0; w < WAYS; w++)
        begin
            ln = line_idx(a, w);
            if (ln < TOTAL_LINES && line_valid[ln] && line_tag[ln] == a[31:13])
                return ln;
        end
        return TOTAL_LINES;
    endfunction

    function automatic logic [31:0] collect(int unsigned ln, int unsigned off, int unsigned len);
        logic [31:0] v;
        logic [31:0] w;
        int unsigned o;
        v = '0;
        for (int unsigned i = 0; i < len; i++)
        begin
            o = (off + i) & 63;
            w = line_data[ln * LINE_WORDS + (o >> 2)];
            v |= ((w >> ((o & 3) * 8)) & 32'hff) << (i * 8);
        end
        return v;
    endfunction

    // Serve the current request part; always yields exactly one result.
    function automatic void serve();
        logic [31:0] a;
        int unsigned ln;
        int unsigned vl;
        while (1)
        begin
            a  = seg_addr();
            ln = find_line(a);
            if (ln >= TOTAL_LINES)
            begin
                victim = lfsr % WAYS;
                lfsr   = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
                vl     = line_idx(a, victim);
                if (vl < TOTAL_LINES)
                    line_valid[vl] = 1'b0;
                word_idx   = 0;
                cache_busy = 1'b1;
                awaited_q.push_back('{RES_FETCH, 32'h0, {a[31:6], 6'b0}});
                return;
            end
            if (!upper_half)
            begin
                joined = collect(ln, a[5:0], seg_len());
                if (head_len() < req_len)
                begin
                    upper_half = 1'b1;
                    continue;
                end
                awaited_q.push_back('{RES_DATA, joined, 32'h0});
                return;
            end
            joined |= collect(ln, 0, seg_len()) << (head_len() * 8);
            upper_half = 1'b0;
            awaited_q.push_back('{RES_DATA, joined, 32'h0});
            return;
        end
    endfunction

    function automatic void predict(logic k, logic [31:0] a, logic [2:0] len, logic [31:0] w);
        logic [31:0] pa;
        int unsigned vl;
        if (k == KIND_READ)
        begin
            if (cache_busy)
                return;
            req_addr   = a;
            req_len    = (len == 0) ? 1 : (len > 4) ? 4 : len;
            upper_half = 1'b0;
            joined     = '0;
            serve();
            return;
        end
        if (!cache_busy)
            return;
        pa = seg_addr();
        vl = line_idx(pa, victim);
        if (vl < TOTAL_LINES)
            line_data[vl * LINE_WORDS + word_idx] = w;
        if (word_idx < LINE_WORDS - 1)
        begin
            word_idx++;
            return;
        end
        word_idx   = 0;
        cache_busy = 1'b0;
        if (vl < TOTAL_LINES)
        begin
            line_valid[vl] = 1'b1;
            line_tag[vl]   = pa[31:13];
        end
        serve();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cache_result_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < TOTAL_LINES; i++)
            begin
                line_valid[i] = 1'b0;
                line_tag[i]   = '0;
            end
            awaited_q.delete();
            req_addr   = '0;
            req_len    = 0;
            upper_half = 1'b0;
            joined     = '0;
            word_idx   = 0;
            victim     = 0;
            cache_busy = 1'b0;
            lfsr       = LFSR_SEED;
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (awaited_q.size() == 0)
                begin
                    $error("unexpected result: kind %0d data %h fetch %h",
                           result_kind, read_data, fetch_address);
                    fail_count++;
                end
                else
                begin
                    e = awaited_q.pop_front();
                    if (result_kind !== e.rkind)
                    begin
                        $error("result_kind: expected %0d, got %0d", e.rkind, result_kind);
                        fail_count++;
                    end
                    if (read_data !== e.data)
                    begin
                        $error("read_data: expected %h, got %h", e.data, read_data);
                        fail_count++;
                    end
                    if (fetch_address !== e.faddr)
                    begin
                        $error("fetch_address: expected %h, got %h", e.faddr, fetch_address);
                        fail_count++;
                    end
                end
            end
            if (push && !full)
                predict(kind, address, length, refill_word);
            pending = awaited_q.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the read cache: drives read requests and line refills, stalls both
// sides at random and gives the verdict. Depends on sarc_pkg, sarc_checker and the cache.
`timescale 1ns / 1ps

module tb_top;
    import sarc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        kind;
    logic [31:0] address;
    logic [2:0]  length;
    logic [31:0] refill_word;
    logic        empty;
    logic        pop;
    logic        result_kind;
    logic [31:0] read_data;
    logic [31:0] fetch_address;

    logic cache_busy;
    int   pending;
    int   fail_count;

    int   tx_idle_pct;
    int   rx_idle_pct;
    logic hold_req;
    int   hold_left;
    int   issued;

    set_assoc_read_cache_random_replace u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .kind          (kind),
        .address       (address),
        .length        (length),
        .refill_word   (refill_word),
        .empty         (empty),
        .pop           (pop),
        .result_kind   (result_kind),
        .read_data     (read_data),
        .fetch_address (fetch_address)
    );

    sarc_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .kind          (kind),
        .address       (address),
        .length        (length),
        .refill_word   (refill_word),
        .empty         (empty),
        .pop           (pop),
        .result_kind   (result_kind),
        .read_data     (read_data),
        .fetch_address (fetch_address),
        .cache_busy    (cache_busy),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("[set_assoc_read_cache_random_replace] ERROR");
        $finish;
    end

    // Result side: random pops, or a long hold-off when asked.
    initial
    begin
        logic hold_done;
        pop       = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done && hold_left == 0)
            begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                pop = 1'b0;
                hold_left--;
            end
            else
                pop = ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Start and end just after a falling edge; return once the request is taken.
    task automatic push_item(logic k, logic [31:0] a, logic [2:0] len, logic [31:0] w);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            push = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        kind        = k;
        address     = a;
        length      = len;
        refill_word = w;
        push        = 1'b1;
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
        issued++;
    endtask

    // Issue a read and feed refill words for as long as the cache waits on a line.
    task automatic cached_read(logic [31:0] a, logic [2:0] len, int noise_pct);
        push_item(KIND_READ, a, len, $urandom);
        while (cache_busy)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                push_item(KIND_READ, $urandom, 3'($urandom_range(0, 7)), $urandom);
            else
                push_item(KIND_REFILL, $urandom, 3'($urandom_range(0, 7)), $urandom);
        end
    endtask

    // Few tags over a handful of sets, so that lines hit, miss and get evicted.
    function automatic logic [31:0] pick_addr();
        logic [18:0] tg;
        logic [6:0]  st;
        logic [5:0]  off;
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        tg  = ($urandom_range(0, 15) == 0) ? 19'h7ffff : 19'($urandom_range(0, 11));
        st  = ($urandom_range(0, 7) == 0) ? 7'h7f : 7'($urandom_range(0, 3));
        off = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(60, 63))
                                          : 6'($urandom_range(0, 63));
        return {tg, st, off};
    endfunction

    task automatic random_phase(int target);
        int stop;
        stop = issued + target;
        while (issued < stop)
        begin
            if ($urandom_range(0, 19) == 0)
                push_item(KIND_REFILL, $urandom, 3'($urandom_range(0, 7)), $urandom);
            else
                cached_read(pick_addr(), 3'($urandom_range(0, 7)), 5);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        push        = 1'b0;
        kind        = KIND_READ;
        address     = '0;
        length      = 3'd1;
        refill_word = '0;
        hold_req    = 1'b0;
        issued      = 0;
        tx_idle_pct = 36;
        rx_idle_pct = 67;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: refill while idle, miss then hit, crossings, wrap, odd lengths.
        push_item(KIND_REFILL, 32'hffffffff, 3'd7, 32'hffffffff);
        cached_read(32'h0000_0000, 3'd1, 0);
        cached_read(32'h0000_0000, 3'd4, 0);
        cached_read(32'h0000_003f, 3'd4, 0);
        cached_read(32'hffff_ffff, 3'd4, 0);
        cached_read(32'hffff_ffc0, 3'd0, 0);
        cached_read(32'hffff_ffc1, 3'd7, 0);
        cached_read(32'h0000_003e, 3'd5, 0);
        cached_read(32'h5555_5555, 3'd3, 50);
        cached_read(32'haaaa_aaaa, 3'd2, 0);
        // Overfill one set so that replacement evicts earlier lines.
        for (int t = 0; t < 10; t++)
            cached_read({19'(t), 7'd5, 6'd8}, 3'd4, 0);
        cached_read({19'd0, 7'd5, 6'd8}, 3'd4, 0);

        // Long result hold-off while requests keep coming.
        hold_req = 1'b1;
        random_phase(350);
        tx_idle_pct = 67;
        rx_idle_pct = 36;
        random_phase(350);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(350);
        push = 1'b0;

        while (pending != 0 || hold_left != 0)
            @(negedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("[set_assoc_read_cache_random_replace] OK");
        else
            $display("[set_assoc_read_cache_random_replace] ERROR");
        $finish;
    end

endmodule
